FILE: rtl/core/jcdr_pkg.sv
// jcdr_pkg: widths, codes, payload and control types for the joystick
// calibration and deadband remap block
// depends on nothing; every file of the block imports it
`default_nettype none

package jcdr_pkg;

    // field widths
    localparam int SAMPLE_BITS = 16;
    localparam int CMD_W       = 16;
    localparam int SCALE_W     = 15;
    localparam int CFG_IDX_W   = 2;

    // remap arithmetic: eight times a sample plus a range, the product
    // with a scale, and the clamped quotient width
    localparam int DIFF_W = SAMPLE_BITS + 6;
    localparam int PROD_W = DIFF_W + SCALE_W + 1;
    localparam int QUO_W  = 18;
    localparam int CNT_W  = $clog2(QUO_W);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LINEAR_SCALE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGULAR_SCALE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REQUIRE_CAL   = 2'd2;

    // input word kinds
    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_TICK   = 1'b1;

    // reset values
    localparam logic [SCALE_W-1:0] LINEAR_SCALE_RST  = 15'd9830;
    localparam logic [SCALE_W-1:0] ANGULAR_SCALE_RST = 15'd29491;
    localparam logic signed [SAMPLE_BITS-1:0] AXIS_LOW_RST    = SAMPLE_BITS'(-32767);
    localparam logic signed [SAMPLE_BITS-1:0] AXIS_HIGH_RST   = SAMPLE_BITS'(32767);
    localparam logic signed [SAMPLE_BITS-1:0] AXIS_CENTRE_RST = SAMPLE_BITS'(16384);

    typedef struct packed {
        logic                          mode;
        logic signed [SAMPLE_BITS-1:0] linear_axis;
        logic signed [SAMPLE_BITS-1:0] angular_axis;
        logic                          button_a;
        logic                          button_b;
        logic                          button_c;
        logic                          deadman_button;
    } jcdr_in_t;

    typedef struct packed {
        logic signed [CMD_W-1:0] linear_command;
        logic signed [CMD_W-1:0] angular_command;
    } jcdr_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MULT,
        ST_LOAD,
        ST_WAIT,
        ST_WRITE
    } jcdr_state_t;

    typedef enum logic {
        AXIS_ANG,
        AXIS_LIN
    } jcdr_axis_t;

    typedef enum logic [1:0] {
        ZONE_NONE,
        ZONE_ABOVE,
        ZONE_BELOW
    } jcdr_zone_t;

    // controller to datapath
    typedef struct packed {
        logic       accept;
        logic       prep;
        logic       mult;
        logic       load;
        logic       write;
        jcdr_axis_t axis;
    } jcdr_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic compute_req;
        logic out_stall;
    } jcdr_status_t;

    // divider to controller
    typedef struct packed {
        logic busy;
        logic done;
    } jcdr_div_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/jcdr_div.sv
// jcdr_div: restoring divider, one quotient bit a cycle, with an overflow
// flag for quotients too wide to matter after clamping
// depends on jcdr_pkg
`default_nettype none

module jcdr_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [jcdr_pkg::PROD_W-1:0]   mag,
    input  wire logic [jcdr_pkg::DIFF_W-1:0]   den,
    output logic      [jcdr_pkg::QUO_W-1:0]    q,
    output logic                               ovf,
    output jcdr_pkg::jcdr_div_status_t         status
);
    import jcdr_pkg::*;

    logic               busy_reg, busy_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DIFF_W:0]    rem_reg, rem_next;
    logic [QUO_W-1:0]   num_reg, num_next;
    logic [QUO_W-1:0]   q_reg, q_next;
    logic               ovf_reg, ovf_next;
    logic [DIFF_W:0]    trial;
    logic [DIFF_W:0]    den_ext;
    logic               ge;

    // one step of the shift and subtract
    always_comb begin
        den_ext = {1'b0, den};
        trial   = {rem_reg[DIFF_W-1:0], num_reg[QUO_W-1]};
        ge      = trial >= den_ext;
    end

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        num_next  = num_reg;
        q_next    = q_reg;
        ovf_next  = ovf_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(QUO_W - 1);
            rem_next  = (DIFF_W + 1)'(mag[PROD_W-1:QUO_W]);
            num_next  = mag[QUO_W-1:0];
            q_next    = '0;
            ovf_next  = (DIFF_W + QUO_W)'(mag) >= {den, {QUO_W{1'b0}}};
        end else if (busy_reg) begin
            rem_next = ge ? (trial - den_ext) : trial;
            q_next   = {q_reg[QUO_W-2:0], ge};
            num_next = num_reg << 1;
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        num_reg <= num_next;
        q_reg   <= q_next;
        ovf_reg <= ovf_next;
    end

    assign q           = q_reg;
    assign ovf         = ovf_reg;
    assign status.busy = busy_reg;
    assign status.done = busy_reg && (cnt_reg == '0);

endmodule

`default_nettype wire

FILE: rtl/core/jcdr_ctrl.sv
// jcdr_ctrl: sequencer that accepts words and steps each axis through
// band test, multiply, divide and write-back
// depends on jcdr_pkg
`default_nettype none

module jcdr_ctrl (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    input  wire logic                       s_mode,
    output logic                            s_ready,
    input  wire jcdr_pkg::jcdr_status_t     status,
    input  wire jcdr_pkg::jcdr_div_status_t div_status,
    output jcdr_pkg::jcdr_cmd_t             cmd
);
    import jcdr_pkg::*;

    jcdr_state_t state_reg, state_next;
    jcdr_axis_t  axis_reg, axis_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            axis_reg  <= AXIS_ANG;
        end else begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        axis_next  = axis_reg;
        cmd        = '0;
        cmd.axis   = axis_reg;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                // a sample never produces a word, so only a tick waits on the output
                s_ready    = (s_mode == MODE_SAMPLE) || !status.out_stall;
                cmd.accept = s_valid && s_ready;
                if (cmd.accept && (s_mode == MODE_SAMPLE) && status.compute_req) begin
                    state_next = ST_PREP;
                    axis_next  = AXIS_ANG;
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = ST_MULT;
            end
            ST_MULT: begin
                cmd.mult   = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                cmd.load   = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (div_status.done) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                cmd.write = 1'b1;
                if (axis_reg == AXIS_ANG) begin
                    axis_next  = AXIS_LIN;
                    state_next = ST_PREP;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/jcdr_dp.sv
// jcdr_dp: calibration state, band test, multiply, command clamp,
// scale registers and the output word register
// depends on jcdr_pkg; the quotient comes from jcdr_div
`default_nettype none

module jcdr_dp (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire jcdr_pkg::jcdr_in_t                s_data,
    input  wire jcdr_pkg::jcdr_cmd_t               cmd,
    output jcdr_pkg::jcdr_status_t                 status,
    input  wire logic                              cfg_we,
    input  wire logic [jcdr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [jcdr_pkg::SCALE_W-1:0]      cfg_wdata,
    input  wire logic [jcdr_pkg::QUO_W-1:0]        div_q,
    input  wire logic                              div_ovf,
    output logic      [jcdr_pkg::PROD_W-1:0]       div_mag,
    output logic      [jcdr_pkg::DIFF_W-1:0]       div_den,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output jcdr_pkg::jcdr_out_t                    m_data
);
    import jcdr_pkg::*;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [DIFF_W-1:0]      diff_t;

    // configuration and flags
    logic [SCALE_W-1:0] lin_scale_reg, lin_scale_next;
    logic [SCALE_W-1:0] ang_scale_reg, ang_scale_next;
    logic               is_cal_reg, is_cal_next;
    logic               enable_held_reg, enable_held_next;
    logic               zero_sent_reg, zero_sent_next;

    // calibration state
    sample_t lin_low_reg, lin_low_next, lin_high_reg, lin_high_next;
    sample_t ang_low_reg, ang_low_next, ang_high_reg, ang_high_next;
    sample_t lin_centre_reg, lin_centre_next, ang_centre_reg, ang_centre_next;
    logic signed [CMD_W-1:0] last_lin_reg, last_lin_next, last_ang_reg, last_ang_next;

    // per-axis working registers
    sample_t             lin_x_reg, lin_x_next, ang_x_reg, ang_x_next;
    jcdr_zone_t          zone_reg, zone_next;
    diff_t               den_reg, den_next;
    diff_t               num_reg, num_next;
    logic [PROD_W-1:0]   mag_reg, mag_next;
    logic                neg_reg, neg_next;
    logic                den_pos_reg, den_pos_next;

    // output word register
    logic       m_valid_reg, m_valid_next;
    jcdr_out_t  m_data_reg, m_data_next;

    // combinational terms
    logic                    widen, capture, cal_after;
    sample_t                 sel_x, sel_lo, sel_hi, sel_c;
    logic [SCALE_W-1:0]      sel_scale;
    diff_t                   x8, lo8, hi8, c8, r;
    logic                    above, below;
    logic signed [PROD_W-1:0] prod;
    logic signed [CMD_W-1:0] scale_s;
    logic [QUO_W:0]          two_scale;
    logic                    over_above, over_below;
    logic signed [QUO_W:0]   q_less_scale;
    logic signed [CMD_W-1:0] cmd_val;

    // button decode
    always_comb begin
        widen     = !is_cal_reg && s_data.button_a && s_data.button_b && s_data.button_c;
        capture   = !is_cal_reg && s_data.button_a && !s_data.button_b && s_data.button_c;
        cal_after = is_cal_reg || capture;
        status.compute_req = cal_after;
        status.out_stall   = m_valid_reg && !m_ready;
    end

    // axis selection
    always_comb begin
        if (cmd.axis == AXIS_ANG) begin
            sel_x     = ang_x_reg;
            sel_lo    = ang_low_reg;
            sel_hi    = ang_high_reg;
            sel_c     = ang_centre_reg;
            sel_scale = ang_scale_reg;
        end else begin
            sel_x     = lin_x_reg;
            sel_lo    = lin_low_reg;
            sel_hi    = lin_high_reg;
            sel_c     = lin_centre_reg;
            sel_scale = lin_scale_reg;
        end
    end

    // band test on eight times the values; below wins when both hold
    always_comb begin
        x8    = DIFF_W'(sel_x) <<< 3;
        lo8   = DIFF_W'(sel_lo) <<< 3;
        hi8   = DIFF_W'(sel_hi) <<< 3;
        c8    = DIFF_W'(sel_c) <<< 3;
        r     = DIFF_W'(sel_hi) - DIFF_W'(sel_lo);
        above = x8 >= (c8 + r);
        below = x8 <= (c8 - r);
    end

    // product of numerator and scale
    always_comb begin
        prod = num_reg * $signed({1'b0, sel_scale});
    end

    // clamp the quotient into a command
    always_comb begin
        scale_s      = $signed(CMD_W'(sel_scale));
        two_scale    = (QUO_W + 1)'({sel_scale, 1'b0});
        over_above   = div_ovf || (div_q > QUO_W'(sel_scale));
        over_below   = div_ovf || ({1'b0, div_q} >= two_scale);
        q_less_scale = $signed({1'b0, div_q}) - $signed((QUO_W + 1)'(sel_scale));
        case (zone_reg)
            ZONE_ABOVE: begin
                if (!den_pos_reg) begin
                    cmd_val = '0;
                end else if (over_above) begin
                    cmd_val = scale_s;
                end else begin
                    cmd_val = $signed(CMD_W'(div_q));
                end
            end
            ZONE_BELOW: begin
                if (!den_pos_reg) begin
                    cmd_val = '0;
                end else if (neg_reg) begin
                    // negative numerator: floor lands below minus scale
                    cmd_val = -scale_s;
                end else if (over_below) begin
                    cmd_val = scale_s;
                end else begin
                    cmd_val = CMD_W'(q_less_scale);
                end
            end
            default: begin
                cmd_val = '0;
            end
        endcase
    end

    // next values
    always_comb begin
        lin_scale_next   = lin_scale_reg;
        ang_scale_next   = ang_scale_reg;
        is_cal_next      = is_cal_reg;
        enable_held_next = enable_held_reg;
        zero_sent_next   = zero_sent_reg;
        lin_low_next     = lin_low_reg;
        lin_high_next    = lin_high_reg;
        ang_low_next     = ang_low_reg;
        ang_high_next    = ang_high_reg;
        lin_centre_next  = lin_centre_reg;
        ang_centre_next  = ang_centre_reg;
        last_lin_next    = last_lin_reg;
        last_ang_next    = last_ang_reg;
        lin_x_next       = lin_x_reg;
        ang_x_next       = ang_x_reg;
        zone_next        = zone_reg;
        den_next         = den_reg;
        num_next         = num_reg;
        mag_next         = mag_reg;
        neg_next         = neg_reg;
        den_pos_next     = den_pos_reg;
        m_valid_next     = m_valid_reg;
        m_data_next      = m_data_reg;

        // output word taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cmd.accept) begin
            if (s_data.mode == MODE_TICK) begin
                // republish while deadman held, otherwise one zero word
                if (enable_held_reg) begin
                    m_data_next.linear_command  = last_lin_reg;
                    m_data_next.angular_command = last_ang_reg;
                    m_valid_next   = 1'b1;
                    zero_sent_next = 1'b0;
                end else if (!zero_sent_reg) begin
                    m_data_next    = '0;
                    m_valid_next   = 1'b1;
                    zero_sent_next = 1'b1;
                end
            end else begin
                if (widen) begin
                    if (s_data.linear_axis > lin_high_reg) lin_high_next = s_data.linear_axis;
                    if (s_data.linear_axis < lin_low_reg) lin_low_next = s_data.linear_axis;
                    if (s_data.angular_axis > ang_high_reg) ang_high_next = s_data.angular_axis;
                    if (s_data.angular_axis < ang_low_reg) ang_low_next = s_data.angular_axis;
                end else if (capture) begin
                    lin_centre_next = s_data.linear_axis;
                    ang_centre_next = s_data.angular_axis;
                    is_cal_next     = 1'b1;
                end
                enable_held_next = s_data.deadman_button && cal_after;
                lin_x_next       = s_data.linear_axis;
                ang_x_next       = s_data.angular_axis;
            end
        end

        // band test and remap terms
        if (cmd.prep) begin
            if (below) begin
                zone_next = ZONE_BELOW;
                den_next  = c8 - r - lo8;
                num_next  = x8 - lo8;
            end else if (above) begin
                zone_next = ZONE_ABOVE;
                den_next  = hi8 - c8 - r;
                num_next  = x8 - c8 - r;
            end else begin
                zone_next = ZONE_NONE;
                den_next  = '0;
                num_next  = '0;
            end
        end

        // magnitude and sign of the product
        if (cmd.mult) begin
            neg_next     = prod[PROD_W-1];
            mag_next     = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
            den_pos_next = den_reg > $signed(DIFF_W'(0));
        end

        if (cmd.write) begin
            if (cmd.axis == AXIS_ANG) begin
                last_ang_next = cmd_val;
            end else begin
                last_lin_next = cmd_val;
            end
        end

        // register writes
        if (cfg_we) begin
            case (cfg_index)
                REG_LINEAR_SCALE:  lin_scale_next = cfg_wdata;
                REG_ANGULAR_SCALE: ang_scale_next = cfg_wdata;
                REG_REQUIRE_CAL:   is_cal_next    = !cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lin_scale_reg   <= LINEAR_SCALE_RST;
            ang_scale_reg   <= ANGULAR_SCALE_RST;
            is_cal_reg      <= 1'b1;
            enable_held_reg <= 1'b0;
            zero_sent_reg   <= 1'b0;
            lin_low_reg     <= AXIS_LOW_RST;
            lin_high_reg    <= AXIS_HIGH_RST;
            ang_low_reg     <= AXIS_LOW_RST;
            ang_high_reg    <= AXIS_HIGH_RST;
            lin_centre_reg  <= AXIS_CENTRE_RST;
            ang_centre_reg  <= AXIS_CENTRE_RST;
            last_lin_reg    <= '0;
            last_ang_reg    <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            lin_scale_reg   <= lin_scale_next;
            ang_scale_reg   <= ang_scale_next;
            is_cal_reg      <= is_cal_next;
            enable_held_reg <= enable_held_next;
            zero_sent_reg   <= zero_sent_next;
            lin_low_reg     <= lin_low_next;
            lin_high_reg    <= lin_high_next;
            ang_low_reg     <= ang_low_next;
            ang_high_reg    <= ang_high_next;
            lin_centre_reg  <= lin_centre_next;
            ang_centre_reg  <= ang_centre_next;
            last_lin_reg    <= last_lin_next;
            last_ang_reg    <= last_ang_next;
            m_valid_reg     <= m_valid_next;
        end
        lin_x_reg   <= lin_x_next;
        ang_x_reg   <= ang_x_next;
        zone_reg    <= zone_next;
        den_reg     <= den_next;
        num_reg     <= num_next;
        mag_reg     <= mag_next;
        neg_reg     <= neg_next;
        den_pos_reg <= den_pos_next;
        m_data_reg  <= m_data_next;
    end

    assign div_mag = mag_reg;
    assign div_den = den_reg[DIFF_W-1:0];
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

FILE: rtl/core/joystick_calibrate_deadband_remap.sv
// joystick_calibrate_deadband_remap: two-axis joystick calibration, deadband
// and linear remap to velocity commands
// depends on jcdr_pkg, jcdr_ctrl, jcdr_dp and jcdr_div
//
// The input channel (s_valid/s_ready/s_data) carries either a joystick sample
// with its buttons or a publish tick, chosen by s_data.mode. The result channel
// (m_valid/m_ready/m_data) carries a linear and an angular command, at most
// one word per tick and none per sample. Scales and the calibration request
// are set through cfg_we/cfg_index/cfg_wdata while the block is idle; the user
// must keep to this, since the block itself does not enforce it. A tick is
// answered from the output register in the cycle after acceptance and the
// block is ready again at once. A calibrated sample keeps the block busy
// after acceptance: per axis a band test, a multiply, a load of the shared
// divider, 18 divider steps (one quotient bit a cycle) and a write-back; an
// uncalibrated sample is done on acceptance.
// While a word waits on m_ready, samples are still taken but a tick is held
// off. Reset (aresetn low, synchronous) restores the default scales, the
// default calibration and an empty output register; no clearing pass.
`default_nettype none

module joystick_calibrate_deadband_remap (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire jcdr_pkg::jcdr_in_t                s_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output jcdr_pkg::jcdr_out_t                    m_data,
    input  wire logic                              cfg_we,
    input  wire logic [jcdr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [jcdr_pkg::SCALE_W-1:0]      cfg_wdata
);
    import jcdr_pkg::*;

    jcdr_cmd_t           cmd;
    jcdr_status_t        status;
    jcdr_div_status_t    div_status;
    logic [QUO_W-1:0]    div_q;
    logic                div_ovf;
    logic [PROD_W-1:0]   div_mag;
    logic [DIFF_W-1:0]   div_den;

    // sequencer
    jcdr_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_mode     (s_data.mode),
        .s_ready    (s_ready),
        .status     (status),
        .div_status (div_status),
        .cmd        (cmd)
    );

    // calibration state and remap arithmetic
    jcdr_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .div_q     (div_q),
        .div_ovf   (div_ovf),
        .div_mag   (div_mag),
        .div_den   (div_den),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // shared divider
    jcdr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.load),
        .mag     (div_mag),
        .den     (div_den),
        .q       (div_q),
        .ovf     (div_ovf),
        .status  (div_status)
    );

`ifndef SYNTH
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> !div_status.busy)
        else $error("divider started while still busy");

    a_done_then_write: assert property (@(posedge aclk) disable iff (!aresetn)
        div_status.done |=> cmd.write)
        else $error("quotient finished but not written back");

    a_ready_divider_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !div_status.busy)
        else $error("input ready while a division runs");

    a_tick_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_data.mode == MODE_TICK)) |-> (!m_valid || m_ready))
        else $error("tick taken while output word is stalled");
`endif

endmodule

`default_nettype wire

FILE: bench/joystick_calibrate_deadband_remap_tb.sv
// joystick_calibrate_deadband_remap_tb: self-checking bench for the joystick calibration,
// deadband and remap block, with its own command predictor and random handshake pressure
// depends on jcdr_pkg and joystick_calibrate_deadband_remap
`timescale 1ns / 1ps

module joystick_calibrate_deadband_remap_tb;
    import jcdr_pkg::*;

    localparam int CYCLE_LIMIT     = 500000;
    localparam int SETTLE_CYCLES   = 64;
    localparam int RX_HOLD_CYCLES  = 300;
    localparam int ROUNDS          = 26;
    localparam int ITEMS_PER_ROUND = 38;
    localparam int PRESSURE_ROUND  = 4;
    localparam int AXIS_MAX        = 32767;
    localparam int BAND_EDGE       = 8192;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct {
        jcdr_in_t word;
        bit       rx_hold;
        bit       wait_drain;
    } pending_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    jcdr_in_t             s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    jcdr_out_t            m_data;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SCALE_W-1:0]   cfg_wdata = '0;

    // bench bookkeeping
    pending_t  joy_words[$];
    jcdr_out_t expected_cmds[$];
    int        words_queued = 0;
    int        words_taken  = 0;
    int        mismatches   = 0;
    int        cycles       = 0;
    int        tx_idle_pct  = 0;
    int        rx_idle_pct  = 0;
    int        hold_left    = 0;
    bit        in_taken     = 1'b0;
    bit        rx_hold_req  = 1'b0;

    // predicted state of the block
    logic [SCALE_W-1:0]            lin_gain     = LINEAR_SCALE_RST;
    logic [SCALE_W-1:0]            ang_gain     = ANGULAR_SCALE_RST;
    logic signed [SAMPLE_BITS-1:0] lin_low      = AXIS_LOW_RST;
    logic signed [SAMPLE_BITS-1:0] lin_high     = AXIS_HIGH_RST;
    logic signed [SAMPLE_BITS-1:0] ang_low      = AXIS_LOW_RST;
    logic signed [SAMPLE_BITS-1:0] ang_high     = AXIS_HIGH_RST;
    logic signed [SAMPLE_BITS-1:0] lin_centre   = AXIS_CENTRE_RST;
    logic signed [SAMPLE_BITS-1:0] ang_centre   = AXIS_CENTRE_RST;
    logic                          calibrated   = 1'b1;
    logic                          deadman_held = 1'b0;
    logic                          zero_done    = 1'b0;
    logic signed [CMD_W-1:0]       held_lin     = '0;
    logic signed [CMD_W-1:0]       held_ang     = '0;

    joystick_calibrate_deadband_remap uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic longint div_floor(input longint n, input longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) q -= 1;
        return q;
    endfunction

    function automatic longint clamp_gain(input longint v, input longint sc);
        if (v > sc) return sc;
        if (v < -sc) return -sc;
        return v;
    endfunction

    // one axis: deadband reaching an eighth of the span either side of the centre, linear remap outside,
    // the below side wins where both tests pass
    function automatic logic signed [CMD_W-1:0] axis_remap(
            input logic signed [SAMPLE_BITS-1:0] x, lo, hi, c,
            input logic [SCALE_W-1:0] gain);
        longint span, x8, c8, sc, den, cmd;
        span = longint'(hi) - longint'(lo);
        x8   = 8 * longint'(x);
        c8   = 8 * longint'(c);
        sc   = longint'(gain);
        cmd  = 0;
        if (x8 >= c8 + span) begin
            den = 8 * longint'(hi) - c8 - span;
            if (den > 0) cmd = clamp_gain(div_floor((x8 - c8 - span) * sc, den), sc);
        end
        if (x8 <= c8 - span) begin
            den = c8 - span - 8 * longint'(lo);
            cmd = 0;
            if (den > 0)
                cmd = clamp_gain(div_floor((x8 - 8 * longint'(lo)) * sc, den) - sc, sc);
        end
        return CMD_W'(cmd);
    endfunction

    // advances the predicted state by one word, returns 1 where a command word comes out
    function automatic bit predict_remap(input jcdr_in_t w, output jcdr_out_t cmd);
        logic signed [SAMPLE_BITS-1:0] lx, ax;
        cmd = '0;
        if (w.mode == MODE_TICK) begin
            if (deadman_held) begin
                cmd.linear_command  = held_lin;
                cmd.angular_command = held_ang;
                zero_done = 1'b0;
                return 1'b1;
            end
            if (!zero_done) begin
                zero_done = 1'b1;
                return 1'b1;
            end
            return 1'b0;
        end
        lx = w.linear_axis;
        ax = w.angular_axis;
        if (w.button_a && w.button_b && w.button_c && !calibrated) begin
            if (lx > lin_high) lin_high = lx;
            if (lx < lin_low) lin_low = lx;
            if (ax > ang_high) ang_high = ax;
            if (ax < ang_low) ang_low = ax;
        end else if (w.button_a && !w.button_b && w.button_c && !calibrated) begin
            lin_centre = lx;
            ang_centre = ax;
            calibrated = 1'b1;
        end
        if (calibrated) begin
            held_ang = axis_remap(ax, ang_low, ang_high, ang_centre, ang_gain);
            held_lin = axis_remap(lx, lin_low, lin_high, lin_centre, lin_gain);
        end
        deadman_held = w.deadman_button && calibrated;
        return 1'b0;
    endfunction

    function automatic jcdr_in_t make_sample(input int lx, ax, input bit a, b, c, dm);
        jcdr_in_t w;
        w                = '0;
        w.mode           = MODE_SAMPLE;
        w.linear_axis    = SAMPLE_BITS'(lx);
        w.angular_axis   = SAMPLE_BITS'(ax);
        w.button_a       = a;
        w.button_b       = b;
        w.button_c       = c;
        w.deadman_button = dm;
        return w;
    endfunction

    // tick fields other than mode carry junk the block must ignore
    function automatic jcdr_in_t make_tick();
        jcdr_in_t w;
        w              = make_sample(int'($urandom_range(65534)) - AXIS_MAX,
                                     int'($urandom_range(65534)) - AXIS_MAX,
                                     $urandom_range(1), $urandom_range(1),
                                     $urandom_range(1), $urandom_range(1));
        w.mode         = MODE_TICK;
        return w;
    endfunction

    // axis value biased towards the extremes, the band edges and the centre
    function automatic int pick_axis(input int centre);
        int v;
        case ($urandom_range(7))
            0:       v = AXIS_MAX;
            1:       v = -AXIS_MAX;
            2:       v = centre + BAND_EDGE + int'($urandom_range(4)) - 2;
            3:       v = centre - BAND_EDGE + int'($urandom_range(4)) - 2;
            4:       v = centre + int'($urandom_range(200)) - 100;
            default: v = int'($urandom_range(65534)) - AXIS_MAX;
        endcase
        if (v > AXIS_MAX) v = AXIS_MAX;
        if (v < -AXIS_MAX) v = -AXIS_MAX;
        return v;
    endfunction

    function automatic logic [SCALE_W-1:0] pick_gain(input logic [SCALE_W-1:0] dflt);
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            2:       return dflt;
            default: return SCALE_W'($urandom);
        endcase
    endfunction

    task automatic queue_word(input jcdr_in_t w, input bit hold, input bit drain);
        pending_t p;
        p.word       = w;
        p.rx_hold    = hold;
        p.wait_drain = drain;
        joy_words.push_back(p);
        words_queued++;
    endtask

    // wait for every word to be taken and every command to arrive, then for the
    // longest sample computation to run out
    task automatic settle();
        while (words_taken != words_queued || expected_cmds.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // writes all registers; a set calibration request drops the calibrated flag
    task automatic program_regs(input logic [SCALE_W-1:0] lin, ang, input bit req,
                                input bit poke_unused);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_LINEAR_SCALE;
        cfg_wdata <= lin;
        @(negedge aclk);
        cfg_index <= REG_ANGULAR_SCALE;
        cfg_wdata <= ang;
        @(negedge aclk);
        cfg_index <= REG_REQUIRE_CAL;
        cfg_wdata <= (SCALE_W'($urandom) & ~SCALE_W'(1)) | SCALE_W'(req);
        if (poke_unused) begin
            @(negedge aclk);
            cfg_index <= REG_UNUSED;
            cfg_wdata <= SCALE_W'($urandom);
        end
        @(negedge aclk);
        cfg_we     <= 1'b0;
        lin_gain   = lin;
        ang_gain   = ang;
        calibrated = !req;
    endtask

    // input driver: next word at the falling edge once the last one was taken
    always @(negedge aclk) begin
        pending_t nxt;
        bit       hold_now;
        hold_now = 1'b0;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (joy_words.size() != 0
                    && !(joy_words[0].wait_drain && expected_cmds.size() != 0)
                    && $urandom_range(99) >= tx_idle_pct) begin
                nxt      = joy_words.pop_front();
                s_valid  <= 1'b1;
                s_data   <= nxt.word;
                hold_now = nxt.rx_hold;
            end else begin
                s_valid <= 1'b0;
            end
        end
        rx_hold_req <= hold_now;
    end

    // result receiver: random stalls, or a long hold-off when asked
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (rx_hold_req) begin
            m_ready   <= 1'b0;
            hold_left <= RX_HOLD_CYCLES;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // monitor: check each command word against the oldest prediction, predict on each input word
    always @(posedge aclk) begin
        jcdr_out_t want;
        jcdr_out_t pred;
        in_taken <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_cmds.size() == 0) begin
                    mismatches++;
                    $display("%0t unexpected word: expected none, got lin %0d ang %0d",
                             $time, m_data.linear_command, m_data.angular_command);
                end else begin
                    want = expected_cmds.pop_front();
                    if (m_data.linear_command !== want.linear_command) begin
                        mismatches++;
                        $display("%0t linear_command: expected %0d, got %0d",
                                 $time, want.linear_command, m_data.linear_command);
                    end
                    if (m_data.angular_command !== want.angular_command) begin
                        mismatches++;
                        $display("%0t angular_command: expected %0d, got %0d",
                                 $time, want.angular_command, m_data.angular_command);
                    end
                end
            end
            if (s_valid && s_ready) begin
                words_taken++;
                if (predict_remap(s_data, pred)) expected_cmds.push_back(pred);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout, %0d commands outstanding", $time, expected_cmds.size());
            $display("** joystick_calibrate_deadband_remap: FAILED **");
            $finish;
        end
    end

    initial begin
        int   round;
        int   k;
        int   lc;
        int   ac;
        bit   recal;
        logic [SCALE_W-1:0] lin;
        logic [SCALE_W-1:0] ang;

        repeat (6) @(negedge aclk);
        aresetn     <= 1'b1;
        tx_idle_pct <= 32;
        rx_idle_pct <= 63;

        // directed, default settings: extremes, band edges, centre, deadman release
        queue_word(make_sample(AXIS_MAX, AXIS_MAX, 0, 0, 0, 1), 0, 0);
        queue_word(make_tick(), 0, 0);
        queue_word(make_sample(-AXIS_MAX, -AXIS_MAX, 0, 0, 0, 1), 0, 0);
        queue_word(make_tick(), 0, 0);
        queue_word(make_sample(16384, 16384, 0, 0, 0, 1), 0, 0);
        queue_word(make_tick(), 0, 0);
        queue_word(make_sample(16384 + BAND_EDGE, 16383 + BAND_EDGE, 0, 0, 0, 1), 0, 0);
        queue_word(make_tick(), 0, 0);
        queue_word(make_sample(16384 - BAND_EDGE, 16385 - BAND_EDGE, 0, 0, 0, 0), 0, 0);
        queue_word(make_tick(), 0, 0);
        queue_word(make_tick(), 0, 0);
        settle();

        // directed, uncalibrated: widen, tick with nothing to send, capture extreme centres
        program_regs('1, '0, 1'b1, 1'b1);
        queue_word(make_sample(AXIS_MAX, -AXIS_MAX, 1, 1, 1, 1), 0, 0);
        queue_word(make_sample(-AXIS_MAX, AXIS_MAX, 1, 1, 1, 0), 0, 0);
        queue_word(make_tick(), 0, 0);
        queue_word(make_sample(AXIS_MAX, -AXIS_MAX, 1, 0, 1, 1), 0, 0);
        queue_word(make_tick(), 0, 0);
        queue_word(make_sample(0, 0, 0, 0, 0, 1), 0, 0);
        queue_word(make_tick(), 0, 0);
        queue_word(make_sample(1, 1, 1, 1, 1, 1), 0, 0);
        queue_word(make_sample(5, 5, 1, 0, 1, 1), 0, 0);
        queue_word(make_tick(), 0, 0);

        // random rounds: new settings, mostly a full calibration, then mixed traffic
        for (round = 0; round < ROUNDS; round++) begin
            settle();
            if (round == ROUNDS / 3) begin
                tx_idle_pct <= 63;
                rx_idle_pct <= 32;
            end else if (round == 2 * ROUNDS / 3) begin
                tx_idle_pct <= 0;
                rx_idle_pct <= 0;
            end
            lin   = pick_gain(LINEAR_SCALE_RST);
            ang   = pick_gain(ANGULAR_SCALE_RST);
            recal = ($urandom_range(9) < 7);
            program_regs(lin, ang, recal, $urandom_range(3) == 0);
            lc = int'(lin_centre);
            ac = int'(ang_centre);
            if (recal) begin
                repeat ($urandom_range(3))
                    queue_word(make_sample(pick_axis(0), pick_axis(0), 1, 1, 1,
                                           $urandom_range(1)), 0, 0);
                // now and then skip the capture, so the block stays uncalibrated until random traffic captures a centre
                if (round == PRESSURE_ROUND || $urandom_range(9) != 0) begin
                    lc = pick_axis(0);
                    ac = pick_axis(0);
                    queue_word(make_sample(lc, ac, 1, 0, 1, $urandom_range(1)), 0, 0);
                end
            end
            if (round == PRESSURE_ROUND) begin
                // receiver stalls while ticks keep coming, so the block backs up
                queue_word(make_sample(pick_axis(lc), pick_axis(ac), 0, 0, 0, 1), 0, 0);
                queue_word(make_tick(), 1, 0);
                repeat (6) queue_word(make_tick(), 0, 0);
                queue_word(make_sample(pick_axis(lc), pick_axis(ac), 0, 0, 0, 1), 0, 0);
                repeat (3) queue_word(make_tick(), 0, 0);
            end
            for (k = 0; k < ITEMS_PER_ROUND; k++) begin
                if ($urandom_range(9) < 4) begin
                    queue_word(make_tick(), 0, k == ITEMS_PER_ROUND / 2);
                end else if ($urandom_range(4) == 0) begin
                    queue_word(make_sample(pick_axis(lc), pick_axis(ac), $urandom_range(1),
                                           $urandom_range(1), $urandom_range(1),
                                           $urandom_range(1)), 0, 0);
                end else begin
                    queue_word(make_sample(pick_axis(lc), pick_axis(ac), 0, 0, 0,
                                           $urandom_range(3) != 0), 0, 0);
                end
            end
        end

        settle();
        if (mismatches == 0) begin
            $display("** joystick_calibrate_deadband_remap: PASSED **");
        end else begin
            $display("** joystick_calibrate_deadband_remap: FAILED **");
        end
        $finish;
    end

endmodule
